// File: src/elfrr_pkg.sv
// ----------------------------------------------------------------------------
// ELF relative relocation patcher package
// Shared codes and the types used between the top level and the core.
// ----------------------------------------------------------------------------
package elfrr_pkg;

  // Input record kinds.
  localparam logic [1:0] KIND_RELA   = 2'd0;
  localparam logic [1:0] KIND_REL    = 2'd1;
  localparam logic [1:0] KIND_RELR   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Patch operation codes.
  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_FAULT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_IMAGE_BASE    = 1'b0;
  localparam logic CFG_RELATIVE_TYPE = 1'b1;

  // Reset value of the accepted relocation type.
  localparam logic [31:0] RELATIVE_TYPE_RST = 32'd8;

  // Configuration seen by the core.
  typedef struct packed {
    logic [63:0] image_base;
    logic [31:0] relative_type;
  } cfg_t;

  // One patch command.
  typedef struct packed {
    logic [63:0] addr;
    logic [1:0]  op;
    logic [63:0] value;
    logic        last;
  } patch_t;

endpackage

// File: src/elfrr_core.sv
// ----------------------------------------------------------------------------
// ELF relative relocation patcher core
// Sequencer around one shared 64-bit adder. Decodes RELA, REL and RELR
// records and produces patch commands, one per set bit while scanning a bitmap.
// ----------------------------------------------------------------------------
module elfrr_core
  import elfrr_pkg::*;
#(
  parameter int WORD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_target_offset,
  input  logic [63:0] in_addend,
  input  logic [31:0] in_type_code,
  input  logic [63:0] in_packed_word,
  output logic        res_valid,
  input  logic        res_ready,
  output patch_t      res
);

  // Bitmap bits per RELR word and the address steps they imply.
  localparam int          BITS   = 8 * WORD_BYTES - 1;
  localparam logic [63:0] STEP   = 64'(WORD_BYTES);
  localparam logic [63:0] STRIDE = 64'(BITS * WORD_BYTES);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADDR = 6'b000010,
    S_VAL  = 6'b000100,
    S_EMIT = 6'b001000,
    S_SCAN = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic             halted_r, halted_nxt;
  logic [63:0]      cursor_r, cursor_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [63:0]      opnd_r, opnd_nxt;
  logic [63:0]      addend_r, addend_nxt;
  logic [63:0]      work_addr_r, work_addr_nxt;
  logic [63:0]      val_r, val_nxt;
  logic [BITS-1:0]  bitmap_r, bitmap_nxt;

  logic [63:0] add_a, add_b, sum;
  logic        in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Shared adder operand selection.
  always_comb begin
    case (state_r)
      S_ADDR: begin
        add_a = cfg.image_base;
        add_b = opnd_r;
      end
      S_VAL: begin
        if (kind_r == KIND_RELA) begin
          add_a = cfg.image_base;
          add_b = addend_r;
        end else begin
          add_a = work_addr_r;
          add_b = STEP;
        end
      end
      S_SCAN: begin
        add_a = work_addr_r;
        add_b = STEP;
      end
      S_FIN: begin
        add_a = cursor_r;
        add_b = STRIDE;
      end
      default: begin
        add_a = cfg.image_base;
        add_b = opnd_r;
      end
    endcase
  end

  assign sum = add_a + add_b;

  // Result presented to the output stage.
  always_comb begin
    res_valid = 1'b0;
    res.addr  = work_addr_r;
    res.op    = op_r;
    res.value = val_r;
    res.last  = 1'b1;
    case (state_r)
      S_EMIT: begin
        res_valid = 1'b1;
      end
      S_SCAN: begin
        res_valid = bitmap_r[0];
        res.op    = OP_ADD;
        res.value = cfg.image_base;
        res.last  = (bitmap_r[BITS-1:1] == '0);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    halted_nxt    = halted_r;
    cursor_nxt    = cursor_r;
    kind_nxt      = kind_r;
    op_nxt        = op_r;
    opnd_nxt      = opnd_r;
    addend_nxt    = addend_r;
    work_addr_nxt = work_addr_r;
    val_nxt       = val_r;
    bitmap_nxt    = bitmap_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && !halted_r && in_kind != KIND_UNUSED) begin
          kind_nxt   = in_kind;
          addend_nxt = in_addend;
          if (in_kind == KIND_RELR) begin
            op_nxt   = OP_ADD;
            opnd_nxt = in_packed_word;
            if (in_packed_word[0]) begin
              // Bitmap word: walk from the current cursor.
              bitmap_nxt    = in_packed_word[BITS:1];
              work_addr_nxt = cursor_r;
              state_nxt     = S_SCAN;
            end else begin
              state_nxt = S_ADDR;
            end
          end else if (in_type_code != cfg.relative_type) begin
            // Unsupported type: one fault, then halt until reset.
            op_nxt        = OP_FAULT;
            work_addr_nxt = '0;
            val_nxt       = '0;
            halted_nxt    = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            op_nxt    = (in_kind == KIND_RELA) ? OP_STORE : OP_ADD;
            opnd_nxt  = in_target_offset;
            state_nxt = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        work_addr_nxt = sum;
        val_nxt       = cfg.image_base;
        state_nxt     = (kind_r == KIND_REL) ? S_EMIT : S_VAL;
      end
      S_VAL: begin
        if (kind_r == KIND_RELA) begin
          val_nxt = sum;
        end else begin
          cursor_nxt = sum;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (bitmap_r == '0) begin
          state_nxt = S_FIN;
        end else if (!bitmap_r[0] || res_ready) begin
          bitmap_nxt    = bitmap_r >> 1;
          work_addr_nxt = sum;
        end
      end
      S_FIN: begin
        cursor_nxt = sum;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      halted_r <= 1'b0;
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      halted_r <= halted_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    op_r        <= op_nxt;
    opnd_r      <= opnd_nxt;
    addend_r    <= addend_nxt;
    work_addr_r <= work_addr_nxt;
    val_r       <= val_nxt;
    bitmap_r    <= bitmap_nxt;
  end

endmodule

// File: src/elf_relative_relocation_patcher_top.sv
// Path to the output register: a REL record passes S_ADDR and S_EMIT, a RELA
// record and a RELR offset word S_ADDR, S_VAL and S_EMIT; a RELR bitmap word
// walks S_SCAN one bitmap position at a time up to its highest set bit, then S_FIN.
// One transaction at a time: a new record is taken only in S_IDLE, and the shared
// 64-bit adder serves every step. Up to 8*WORD_BYTES-1 results leave per bitmap word.
// Reset (rst_n, synchronous): idle, cursor 0, not halted, relative_type 8.
// ----------------------------------------------------------------------------
// ELF relative relocation patcher top level
// Configuration registers, the decoding core and the output register.
// ----------------------------------------------------------------------------
module elf_relative_relocation_patcher_top
  import elfrr_pkg::*;
#(
  parameter int WORD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_target_offset,
  input  logic [63:0] in_addend,
  input  logic [31:0] in_type_code,
  input  logic [63:0] in_packed_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_patch_address,
  output logic [1:0]  out_patch_op,
  output logic [63:0] out_patch_value,
  output logic        out_last
);

  cfg_t   cfg_r;
  logic   res_valid, res_ready;
  patch_t res;
  logic   out_valid_r;
  patch_t out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_base    <= '0;
      cfg_r.relative_type <= RELATIVE_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_BASE:    cfg_r.image_base    <= cfg_wdata;
        CFG_RELATIVE_TYPE: cfg_r.relative_type <= cfg_wdata[31:0];
        default:           cfg_r.image_base    <= cfg_r.image_base;
      endcase
    end
  end

  elfrr_core #(
    .WORD_BYTES(WORD_BYTES)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_target_offset (in_target_offset),
    .in_addend        (in_addend),
    .in_type_code     (in_type_code),
    .in_packed_word   (in_packed_word),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  // Output register: loads whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_patch_address = out_r.addr;
  assign out_patch_op      = out_r.op;
  assign out_patch_value   = out_r.value;
  assign out_last          = out_r.last;

endmodule

// File: tb/sv/tb_elf_relative_relocation_patcher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ELF relative relocation patcher testbench
// Drives RELA, REL and packed RELR records through the input channel, predicts
// patch commands from its own copy of the base, type, cursor and halt flag or
// takes them from hand-written rows, and checks each output transaction in
// order. Both sides idle at random, the output side stalls once for a long
// stretch, and the registers go through several settings, extremes included.
// ----------------------------------------------------------------------------
module tb_elf_relative_relocation_patcher_top;
  import elfrr_pkg::*;

  localparam int WB = 8;
  localparam int BITMAP_BITS = 8 * WB - 1;
  localparam int HALF_HIGH_NS = 5;
  localparam int HALF_LOW_NS = 5;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_IDLE = 8;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 30;
  localparam int CLOSING_ROWS = 5;
  localparam longint LIMIT_NS = 20_000_000;
  localparam logic [63:0] ONES = '1;
  localparam logic [31:0] ONES32 = '1;

  // One row of stimulus: a register write or an input transaction, with an
  // optional hand-written expectation.
  typedef struct {
    bit          is_reg;
    logic        reg_idx;
    logic [63:0] reg_data;
    logic [1:0]  kind;
    logic [63:0] target_offset;
    logic [63:0] addend;
    logic [31:0] type_code;
    logic [63:0] packed_word;
    bit          pinned;
    bit          pinned_has;
    patch_t      pinned_patch;
  } reloc_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [63:0] in_target_offset;
  logic [63:0] in_addend;
  logic [31:0] in_type_code;
  logic [63:0] in_packed_word;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_patch_address;
  logic [1:0]  out_patch_op;
  logic [63:0] out_patch_value;
  logic        out_last;

  // Predictor state and the store of patch commands still to arrive.
  logic [63:0] img_base = '0;
  logic [31:0] accept_type = RELATIVE_TYPE_RST;
  logic [63:0] relr_cursor = '0;
  bit          halted_f = 1'b0;
  patch_t      item_patches[$];
  patch_t      pending_patches[$];

  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int errors = 0;

  elf_relative_relocation_patcher_top #(
    .WORD_BYTES(WB)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_target_offset (in_target_offset),
    .in_addend        (in_addend),
    .in_type_code     (in_type_code),
    .in_packed_word   (in_packed_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_patch_address(out_patch_address),
    .out_patch_op     (out_patch_op),
    .out_patch_value  (out_patch_value),
    .out_last         (out_last)
  );

  always begin
    clk = 1'b0;
    #(HALF_LOW_NS);
    clk = 1'b1;
    #(HALF_HIGH_NS);
  end

  // Row builders for the stimulus table.
  function automatic reloc_row_t record_row(input logic [1:0] k, input logic [63:0] toff,
                                            input logic [63:0] add, input logic [31:0] ty,
                                            input logic [63:0] pw);
    reloc_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = CFG_IMAGE_BASE;
    r.reg_data = '0;
    r.kind = k;
    r.target_offset = toff;
    r.addend = add;
    r.type_code = ty;
    r.packed_word = pw;
    r.pinned = 1'b0;
    r.pinned_has = 1'b0;
    r.pinned_patch = '0;
    return r;
  endfunction

  function automatic reloc_row_t fixed_row(input logic [1:0] k, input logic [63:0] toff,
                                           input logic [63:0] add, input logic [31:0] ty,
                                           input logic [63:0] pw, input logic [63:0] addr,
                                           input logic [1:0] op, input logic [63:0] val);
    reloc_row_t r;
    r = record_row(k, toff, add, ty, pw);
    r.pinned = 1'b1;
    r.pinned_has = 1'b1;
    r.pinned_patch = '{addr: addr, op: op, value: val, last: 1'b1};
    return r;
  endfunction

  function automatic reloc_row_t silent_row(input logic [1:0] k, input logic [63:0] toff,
                                            input logic [63:0] add, input logic [31:0] ty,
                                            input logic [63:0] pw);
    reloc_row_t r;
    r = record_row(k, toff, add, ty, pw);
    r.pinned = 1'b1;
    return r;
  endfunction

  function automatic reloc_row_t reg_row(input logic idx, input logic [63:0] data);
    reloc_row_t r;
    r = record_row(KIND_UNUSED, '0, '0, '0, '0);
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Works out the patch commands of one accepted transaction and updates the
  // predictor state.
  function automatic void decode_record(input reloc_row_t r);
    logic [63:0] where;
    item_patches.delete();
    if (halted_f || r.kind == KIND_UNUSED) return;
    if (r.kind != KIND_RELR) begin
      if (r.type_code != accept_type) begin
        item_patches.push_back('{addr: '0, op: OP_FAULT, value: '0, last: 1'b0});
        halted_f = 1'b1;
      end else if (r.kind == KIND_RELA) begin
        item_patches.push_back('{addr: img_base + r.target_offset, op: OP_STORE,
                                 value: img_base + r.addend, last: 1'b0});
      end else begin
        item_patches.push_back('{addr: img_base + r.target_offset, op: OP_ADD,
                                 value: img_base, last: 1'b0});
      end
    end else if (!r.packed_word[0]) begin
      // Offset word: patch it and restart the bitmap run right after it.
      where = img_base + r.packed_word;
      item_patches.push_back('{addr: where, op: OP_ADD, value: img_base, last: 1'b0});
      relr_cursor = where + 64'(WB);
    end else begin
      // Bitmap word: bit i covers the word i-1 places past the cursor.
      for (int i = 1; i <= BITMAP_BITS && i < 64; i++) begin
        if (r.packed_word[i]) begin
          item_patches.push_back('{addr: relr_cursor + 64'(i - 1) * 64'(WB), op: OP_ADD,
                                   value: img_base, last: 1'b0});
        end
      end
      relr_cursor = relr_cursor + 64'(BITMAP_BITS) * 64'(WB);
    end
    if (item_patches.size() != 0) item_patches[item_patches.size() - 1].last = 1'b1;
  endfunction

  function automatic int unsigned idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Bitmap words of varied density, the empty one among them.
  function automatic logic [63:0] draw_bitmap();
    case ($urandom_range(0, 5))
      0: return rand64() | 64'd1;
      1: return (64'd1 << $urandom_range(1, 63)) | 64'd1;
      2: return ONES;
      3: return 64'd1;
      default: return (rand64() & rand64() & rand64()) | 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] draw_offset();
    if ($urandom_range(0, 3) == 0) return rand64() & ~64'd1;
    return 64'($urandom_range(0, 4095) * 8);
  endfunction

  // Offers one input transaction after a random gap and records what it causes.
  task automatic offer(input reloc_row_t r);
    int unsigned gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_target_offset <= r.target_offset;
    in_addend <= r.addend;
    in_type_code <= r.type_code;
    in_packed_word <= r.packed_word;
    do @(posedge clk); while (in_ready !== 1'b1);
    decode_record(r);
    if (r.pinned) begin
      if (r.pinned_has) pending_patches.push_back(r.pinned_patch);
    end else begin
      foreach (item_patches[j]) pending_patches.push_back(item_patches[j]);
    end
  endtask

  // Waits until every expected transaction is out and the core has gone quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_patches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_IMAGE_BASE) img_base = data;
    else accept_type = data[31:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_row(input reloc_row_t r);
    if (r.is_reg) begin
      settle();
      write_reg(r.reg_idx, r.reg_data);
    end else begin
      offer(r);
    end
  endtask

  // Output side: random stalls, one long hold on request, in-order checking.
  initial begin : drain_outputs
    int unsigned stall;
    patch_t want;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_draw();
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_patches.size() == 0) begin
        $display("%0t: unexpected patch: address %h op %0d value %h last %b", $time,
                 out_patch_address, out_patch_op, out_patch_value, out_last);
        errors++;
      end else begin
        want = pending_patches.pop_front();
        if (out_patch_address !== want.addr) begin
          $display("%0t: patch_address expected %h, got %h", $time, want.addr,
                   out_patch_address);
          errors++;
        end
        if (out_patch_op !== want.op) begin
          $display("%0t: patch_op expected %0d, got %0d", $time, want.op, out_patch_op);
          errors++;
        end
        if (out_patch_value !== want.value) begin
          $display("%0t: patch_value expected %h, got %h", $time, want.value,
                   out_patch_value);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %b, got %b", $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    reloc_row_t plan[$];
    int unsigned counted;
    int unsigned run_len;
    int tail_start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_BASE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = KIND_RELA;
    in_target_offset = '0;
    in_addend = '0;
    in_type_code = '0;
    in_packed_word = '0;
    out_ready = 1'b0;

    plan = '{
      // Reset settings: base 0, accepted type 8.
      fixed_row(KIND_RELA, 64'd0, 64'd0, 32'd8, 64'd0, 64'd0, OP_STORE, 64'd0),
      fixed_row(KIND_RELA, ONES, ONES, 32'd8, ONES, ONES, OP_STORE, ONES),
      fixed_row(KIND_REL, ONES, ONES, 32'd8, ONES, ONES, OP_ADD, 64'd0),
      // A bitmap before any offset word runs from address 0.
      record_row(KIND_RELR, ONES, ONES, ONES32, ONES),
      fixed_row(KIND_RELR, 64'd0, 64'd0, 32'd0, 64'd0, 64'd0, OP_ADD, 64'd0),
      // An empty bitmap causes nothing, but the cursor still moves.
      silent_row(KIND_RELR, 64'd0, 64'd0, 32'd0, 64'd1),
      record_row(KIND_RELR, 64'd0, 64'd0, 32'd0, 64'h8000_0000_0000_0001),
      silent_row(KIND_UNUSED, ONES, ONES, ONES32, ONES),
      // Offset word at the top of memory, so the next bitmap wraps.
      fixed_row(KIND_RELR, ONES, ONES, ONES32, 64'hFFFF_FFFF_FFFF_FFFE,
                64'hFFFF_FFFF_FFFF_FFFE, OP_ADD, 64'd0),
      record_row(KIND_RELR, 64'd0, 64'd0, 32'd0, 64'h5),
      record_row(KIND_RELR, 64'd0, 64'd0, 32'd0, 64'hAAAA_AAAA_AAAA_AAAB),
      // Largest base and type: any sum with a nonzero operand wraps.
      reg_row(CFG_IMAGE_BASE, ONES),
      reg_row(CFG_RELATIVE_TYPE, {32'd0, ONES32}),
      fixed_row(KIND_RELA, 64'd1, 64'd1, ONES32, 64'd0, 64'd0, OP_STORE, 64'd0),
      fixed_row(KIND_REL, 64'd0, 64'd0, ONES32, 64'd0, ONES, OP_ADD, ONES),
      record_row(KIND_RELR, 64'd0, 64'd0, 32'd0, 64'd2),
      record_row(KIND_RELR, 64'd0, 64'd0, 32'd0, ONES),
      // Smallest type with an ordinary base.
      reg_row(CFG_RELATIVE_TYPE, 64'd0),
      reg_row(CFG_IMAGE_BASE, 64'h0000_0000_0040_0000),
      record_row(KIND_RELA, 64'h10, 64'h20, 32'd0, 64'd0),
      record_row(KIND_REL, 64'h18, 64'd0, 32'd0, 64'd0),
      // A wrong type halts the block until reset, so these rows run last.
      reg_row(CFG_RELATIVE_TYPE, {32'd0, RELATIVE_TYPE_RST}),
      fixed_row(KIND_REL, 64'h40, 64'd0, 32'd9, 64'd0, 64'd0, OP_FAULT, 64'd0),
      silent_row(KIND_RELA, 64'd0, 64'd0, 32'd8, 64'd0),
      silent_row(KIND_RELR, 64'd0, 64'd0, 32'd0, 64'h100),
      silent_row(KIND_RELR, 64'd0, 64'd0, 32'd0, ONES)
    };
    tail_start = plan.size() - CLOSING_ROWS;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < tail_start; k++) run_row(plan[k]);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(CFG_IMAGE_BASE, (ph == 0) ? ONES : (ph == 1) ? 64'd0 : rand64());
      write_reg(CFG_RELATIVE_TYPE, (ph == 1) ? 64'd0 :
                (ph == 3) ? {32'd0, ONES32} : {32'd0, $urandom});
      no_idle = (ph == 2 || ph == 5);
      // The long output hold lands in a phase where the input never idles.
      if (ph == 2) hold_req = 1'b1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // Well-formed RELR run: one offset word and a few bitmaps.
            run_len = $urandom_range(1, 4);
            offer(record_row(KIND_RELR, rand64(), rand64(), $urandom, draw_offset()));
            repeat (run_len)
              offer(record_row(KIND_RELR, rand64(), rand64(), $urandom, draw_bitmap()));
            counted += run_len + 1;
          end
          4, 5: begin
            offer(record_row(KIND_RELA, rand64(), rand64(), accept_type, rand64()));
            counted++;
          end
          6, 7: begin
            offer(record_row(KIND_REL, rand64(), rand64(), accept_type, rand64()));
            counted++;
          end
          8: begin
            // Bitmap with no fresh offset word ahead of it.
            offer(record_row(KIND_RELR, rand64(), rand64(), $urandom, draw_bitmap()));
            counted++;
          end
          default: begin
            offer(record_row(KIND_UNUSED, rand64(), rand64(), $urandom, rand64()));
          end
        endcase
      end
    end
    no_idle = 1'b0;

    for (int k = tail_start; k < plan.size(); k++) run_row(plan[k]);
    settle();

    if (errors == 0) begin
      $display("[elf_relative_relocation_patcher_top] OK");
    end else begin
      $display("[elf_relative_relocation_patcher_top] ERROR");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("[elf_relative_relocation_patcher_top] ERROR");
    $finish;
  end

endmodule

// File: elf_relative_relocation_patcher_top.f
src/elfrr_pkg.sv
src/elfrr_core.sv
src/elf_relative_relocation_patcher_top.sv
tb/sv/tb_elf_relative_relocation_patcher_top.sv
